@@ hdl/fegr_pkg.sv @@
package fegr_pkg;

    localparam int EXP_TERMS = 15;
    localparam int SER_STEPS = EXP_TERMS - 2;
    localparam int INT_STEPS = 31;
    localparam int RATE_LAT  = 2 + 3 * SER_STEPS + 1 + INT_STEPS + 2;
    localparam int DIV_BITS  = 32;
    localparam int TOP_LAT   = RATE_LAT + DIV_BITS + 3;

    localparam int MODE_PERSIST      = 0;
    localparam int MODE_SHRINK_PLUS  = 1;
    localparam int MODE_SHRINK_MINUS = 2;

    typedef enum logic [2:0] {
        REG_GROW    = 3'd0,
        REG_SHRINK  = 3'd1,
        REG_OFF     = 3'd2,
        REG_SCALE   = 3'd3,
        REG_MIN_LEN = 3'd4,
        REG_MAX_LEN = 3'd5,
        REG_MODE    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        LIM_BELOW,
        LIM_WITHIN,
        LIM_REACH,
        LIM_ABOVE
    } lim_cls_t;

    typedef struct packed {
        logic [31:0]        grow;
        logic [31:0]        scale;
        logic signed [31:0] off;
        logic signed [31:0] shrink;
    } end_cfg_t;

    typedef struct packed {
        logic signed [31:0] force_v;
        logic               shrink_sel;
        logic               active;
        logic [16:0]        frac;
    } end_in_t;

    typedef struct packed {
        logic [31:0] term;
        logic        neg;
        logic        shrink_sel;
        logic        active;
    } end_side_t;

    typedef struct packed {
        logic [31:0]        x;
        logic [31:0]        t;
        logic signed [34:0] sum;
        logic [4:0]         nint;
        logic               big;
        end_side_t          side;
    } ser_t;

    typedef struct packed {
        logic [32:0] fac;
        logic [4:0]  nint;
        end_side_t   side;
    } pow_t;

    typedef struct packed {
        logic signed [31:0] rp;
        logic signed [31:0] rm;
        lim_cls_t           cls;
        logic               sp;
        logic               sm;
    } lim_t;

    // exp(-1) in Q0.32 as the square of the truncated series at one half
    function automatic logic [31:0] exp_m1_q32();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        for (int k = 1; k < EXP_TERMS; k++)
        begin
            term = ((term * 64'h8000_0000) >> 32) / 64'(k);
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        prod = (sum * sum) >> 32;
        return prod[31:0];
    endfunction

    localparam logic [31:0] E1_Q32 = exp_m1_q32();

endpackage

@@ hdl/fegr_in_if.sv @@
interface fegr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_plus;
    logic signed [31:0] force_minus;
    logic               outside_plus;
    logic               outside_minus;
    logic               active_plus;
    logic               active_minus;
    logic [30:0]        cur_length;
    logic [16:0]        free_fraction;

    modport source (
        output valid, force_plus, force_minus, outside_plus, outside_minus,
               active_plus, active_minus, cur_length, free_fraction,
        input  ready
    );
    modport sink (
        input  valid, force_plus, force_minus, outside_plus, outside_minus,
               active_plus, active_minus, cur_length, free_fraction,
        output ready
    );
endinterface

@@ hdl/fegr_out_if.sv @@
interface fegr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_plus;
    logic signed [31:0] rate_minus;
    logic signed [31:0] applied_plus;
    logic signed [31:0] applied_minus;
    logic               remove_fiber;

    modport source (
        output valid, rate_plus, rate_minus, applied_plus, applied_minus, remove_fiber,
        input  ready
    );
    modport sink (
        input  valid, rate_plus, rate_minus, applied_plus, applied_minus, remove_fiber,
        output ready
    );
endinterface

@@ hdl/fegr_rate.sv @@
module fegr_rate
    import fegr_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  end_cfg_t           cfg,
    input  end_in_t            item,
    output logic signed [31:0] rate
);

    logic [31:0]        mag;
    logic [48:0]        grow_frac;
    logic [63:0]        mag_scale;
    end_side_t          s1_side_reg;
    logic [47:0]        s1_m_reg;
    logic [31:0]        f0;
    logic signed [34:0] sum0;
    ser_t               ser_reg [0:SER_STEPS];
    pow_t               pow_reg [0:INT_STEPS];
    pow_t               pow0;
    logic [64:0]        dprod;
    logic [31:0]        dmp_reg;
    end_side_t          dmp_side_reg;
    logic signed [33:0] r34;
    logic signed [31:0] rate_next;
    logic signed [31:0] rate_reg;

    always_comb
    begin
        mag       = item.force_v[31] ? 32'(~item.force_v + 32'd1) : 32'(item.force_v);
        grow_frac = 49'(cfg.grow) * 49'(item.frac);
        mag_scale = 64'(mag) * 64'(cfg.scale);
    end

    // stage 1: assembly term and exponent magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg.term       <= grow_frac[47:16];
            s1_side_reg.neg        <= item.force_v[31];
            s1_side_reg.shrink_sel <= item.shrink_sel;
            s1_side_reg.active     <= item.active;
            s1_m_reg               <= mag_scale[63:16];
        end
    end

    // stage 2: split exponent, first series term
    assign f0   = {s1_m_reg[15:0], 16'h0000};
    assign sum0 = 35'sh1_0000_0000 - $signed({3'b000, f0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ser_reg[0].x    <= f0;
            ser_reg[0].t    <= f0;
            ser_reg[0].sum  <= sum0;
            ser_reg[0].nint <= s1_m_reg[20:16];
            ser_reg[0].big  <= |s1_m_reg[47:21];
            ser_reg[0].side <= s1_side_reg;
        end
    end

    // series terms, three stages each: multiply, reciprocal, correct and accumulate
    for (genvar j = 0; j < SER_STEPS; j++)
    begin : g_ser
        localparam int K = j + 2;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
        localparam logic [31:0] KV = 32'(K);

        ser_t        a_reg;
        ser_t        b_reg;
        ser_t        nxt;
        logic [31:0] a_p_reg;
        logic [31:0] b_p_reg;
        logic [31:0] b_q_reg;
        logic [63:0] a_prod;
        logic [63:0] b_prod;
        logic [31:0] rem;
        logic [31:0] quo;

        assign a_prod = 64'(ser_reg[j].t) * 64'(ser_reg[j].x);
        assign b_prod = 64'(a_p_reg) * 64'(RECIP);

        always_comb
        begin
            rem   = b_p_reg - b_q_reg * KV;
            quo   = (rem >= KV) ? b_q_reg + 32'd1 : b_q_reg;
            nxt   = b_reg;
            nxt.t = quo;
            if (K % 2 == 1)
                nxt.sum = b_reg.sum - $signed({3'b000, quo});
            else
                nxt.sum = b_reg.sum + $signed({3'b000, quo});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg        <= ser_reg[j];
                a_p_reg      <= a_prod[63:32];
                b_reg        <= a_reg;
                b_p_reg      <= a_p_reg;
                b_q_reg      <= b_prod[63:32];
                ser_reg[j+1] <= nxt;
            end
        end
    end

    always_comb
    begin
        pow0.nint = ser_reg[SER_STEPS].nint;
        pow0.side = ser_reg[SER_STEPS].side;
        if (ser_reg[SER_STEPS].big || ser_reg[SER_STEPS].sum[34])
            pow0.fac = '0;
        else
            pow0.fac = ser_reg[SER_STEPS].sum[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pow_reg[0] <= pow0;
    end

    // integer part: stage i multiplies by exp(-1), truncating, if i < nint
    for (genvar i = 0; i < INT_STEPS; i++)
    begin : g_pow
        logic [64:0] prod;
        pow_t        nxt;

        assign prod = 65'(pow_reg[i].fac) * 65'(E1_Q32);

        always_comb
        begin
            nxt = pow_reg[i];
            if (pow_reg[i].nint > 5'(i))
                nxt.fac = prod[64:32];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pow_reg[i+1] <= nxt;
        end
    end

    assign dprod = 65'(pow_reg[INT_STEPS].side.term) * 65'(pow_reg[INT_STEPS].fac);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmp_reg      <= pow_reg[INT_STEPS].side.neg ? dprod[63:32]
                                                        : pow_reg[INT_STEPS].side.term;
            dmp_side_reg <= pow_reg[INT_STEPS].side;
        end
    end

    always_comb
    begin
        r34 = $signed({2'b00, dmp_reg}) + $signed({{2{cfg.off[31]}}, cfg.off});
        if (dmp_side_reg.shrink_sel)
            rate_next = cfg.shrink;
        else if (!dmp_side_reg.active)
            rate_next = '0;
        else if (r34 > 34'sd2147483647)
            rate_next = 32'sh7FFF_FFFF;
        else if (r34 < -34'sd2147483648)
            rate_next = 32'sh8000_0000;
        else
            rate_next = r34[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rate_reg <= rate_next;
    end

    assign rate = rate_reg;

endmodule

@@ hdl/fegr_div.sv @@
module fegr_div
    import fegr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);

    logic [31:0] rem_reg [0:DIV_BITS-1];
    logic [31:0] low_reg [0:DIV_BITS-1];
    logic [31:0] den_reg [0:DIV_BITS-1];
    logic [31:0] q_reg   [0:DIV_BITS-1];

    // one quotient bit per stage, remainder stays below the divisor
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_bit
        logic [31:0] rem_i;
        logic [31:0] low_i;
        logic [31:0] den_i;
        logic [31:0] q_i;
        logic [32:0] trial;
        logic [32:0] diff;

        if (j == 0)
        begin : g_first
            assign rem_i = {1'b0, num[62:32]};
            assign low_i = num[31:0];
            assign den_i = den;
            assign q_i   = '0;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[j-1];
            assign low_i = low_reg[j-1];
            assign den_i = den_reg[j-1];
            assign q_i   = q_reg[j-1];
        end

        assign trial = {rem_i, low_i[31]};
        assign diff  = trial - {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, den_i})
                begin
                    rem_reg[j] <= diff[31:0];
                    q_reg[j]   <= {q_i[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= trial[31:0];
                    q_reg[j]   <= {q_i[30:0], 1'b0};
                end
                low_reg[j] <= {low_i[30:0], 1'b0};
                den_reg[j] <= den_i;
            end
        end
    end

    assign quo = q_reg[DIV_BITS-1];

endmodule

@@ hdl/fiber_end_growth_rate_core.sv @@
// channel  | dir  | handshake     | payload
// fiber    | in   | valid/ready   | forces, outside and active flags, length, free fraction
// growth   | out  | valid/ready   | rates, applied growth, remove flag
// cfg      | in   | cfg_we        | cfg_index, cfg_data
//
// one item per cycle sustained while growth is ready; the path runs through the end rate
// (series and exp(-1) power stages), the limit check and scaling multiply,
// the bit-per-stage divider and the output register
// rst_n clears config registers (max length to all ones) and valid bits, no clearing pass
// a stall on growth holds every stage at once, so nothing is lost or repeated
module fiber_end_growth_rate_core
    import fegr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fegr_in_if.sink     fiber,
    fegr_out_if.source  growth,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] grow_reg;
    logic [63:0] shrink_reg;
    logic [63:0] off_reg;
    logic [63:0] scale_reg;
    logic [30:0] min_len_reg;
    logic [30:0] max_len_reg;
    logic [2:0]  mode_reg;

    logic        en;
    logic        vld_reg [0:TOP_LAT-1];
    logic [30:0] len_reg [0:RATE_LAT-1];
    logic [16:0] frac_sat;
    end_cfg_t    plus_cfg;
    end_cfg_t    minus_cfg;
    end_in_t     plus_in;
    end_in_t     minus_in;
    logic signed [31:0] rp;
    logic signed [31:0] rm;

    logic signed [32:0] inc;
    logic signed [34:0] tot;
    lim_t        lim_next;
    logic [31:0] magp;
    logic [31:0] magm;
    logic [30:0] diff;
    logic [31:0] den;
    lim_t        lim_reg [0:DIV_BITS+1];
    logic [31:0] magp_reg;
    logic [31:0] magm_reg;
    logic [30:0] diff_reg;
    logic [31:0] den1_reg;
    logic [62:0] nump_reg;
    logic [62:0] numm_reg;
    logic [31:0] den2_reg;
    logic [31:0] qp;
    logic [31:0] qm;

    lim_t        lim_o;
    logic signed [31:0] rate_plus_next;
    logic signed [31:0] rate_minus_next;
    logic signed [31:0] applied_plus_next;
    logic signed [31:0] applied_minus_next;
    logic        remove_next;
    logic signed [31:0] rate_plus_reg;
    logic signed [31:0] rate_minus_reg;
    logic signed [31:0] applied_plus_reg;
    logic signed [31:0] applied_minus_reg;
    logic        remove_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_reg    <= '0;
            shrink_reg  <= '0;
            off_reg     <= '0;
            scale_reg   <= '0;
            min_len_reg <= '0;
            max_len_reg <= 31'h7FFF_FFFF;
            mode_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GROW:    grow_reg    <= cfg_data;
                REG_SHRINK:  shrink_reg  <= cfg_data;
                REG_OFF:     off_reg     <= cfg_data;
                REG_SCALE:   scale_reg   <= cfg_data;
                REG_MIN_LEN: min_len_reg <= cfg_data[30:0];
                REG_MAX_LEN: max_len_reg <= cfg_data[30:0];
                REG_MODE:    mode_reg    <= cfg_data[2:0];
                default:     ;
            endcase
        end
    end

    // whole pipeline advances together
    assign en          = !vld_reg[TOP_LAT-1] || growth.ready;
    assign fiber.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= fiber.valid;
            for (int i = 1; i < TOP_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= fiber.cur_length;
            for (int i = 1; i < RATE_LAT; i++)
                len_reg[i] <= len_reg[i-1];
        end
    end

    always_comb
    begin
        frac_sat = (fiber.free_fraction > 17'd65536) ? 17'd65536 : fiber.free_fraction;

        plus_cfg.grow    = grow_reg[31:0];
        plus_cfg.scale   = scale_reg[31:0];
        plus_cfg.off     = off_reg[31:0];
        plus_cfg.shrink  = shrink_reg[31:0];
        minus_cfg.grow   = grow_reg[63:32];
        minus_cfg.scale  = scale_reg[63:32];
        minus_cfg.off    = off_reg[63:32];
        minus_cfg.shrink = shrink_reg[63:32];

        plus_in.force_v     = fiber.force_plus;
        plus_in.shrink_sel  = mode_reg[MODE_SHRINK_PLUS] & fiber.outside_plus;
        plus_in.active      = fiber.active_plus;
        plus_in.frac        = frac_sat;
        minus_in.force_v    = fiber.force_minus;
        minus_in.shrink_sel = mode_reg[MODE_SHRINK_MINUS] & fiber.outside_minus;
        minus_in.active     = fiber.active_minus;
        minus_in.frac       = frac_sat;
    end

    fegr_rate u_rate_plus
    (
        .clk  (clk),
        .en   (en),
        .cfg  (plus_cfg),
        .item (plus_in),
        .rate (rp)
    );

    fegr_rate u_rate_minus
    (
        .clk  (clk),
        .en   (en),
        .cfg  (minus_cfg),
        .item (minus_in),
        .rate (rm)
    );

    // limit check against min and max length
    always_comb
    begin
        inc = {rp[31], rp} + {rm[31], rm};
        tot = $signed({4'b0000, len_reg[RATE_LAT-1]}) + $signed({{2{inc[32]}}, inc});
        lim_next.rp = rp;
        lim_next.rm = rm;
        lim_next.sp = rp[31];
        lim_next.sm = rm[31];
        priority if (tot < $signed({4'b0000, min_len_reg}))
            lim_next.cls = LIM_BELOW;
        else if (tot < $signed({4'b0000, max_len_reg}))
            lim_next.cls = LIM_WITHIN;
        else if (len_reg[RATE_LAT-1] < max_len_reg && inc > 33'sd0)
            lim_next.cls = LIM_REACH;
        else if (len_reg[RATE_LAT-1] < max_len_reg)
            lim_next.cls = LIM_WITHIN;
        else
            lim_next.cls = LIM_ABOVE;
        // reaching max with no positive sum counts as within and applies both rates
        if (lim_next.cls == LIM_WITHIN && !(tot < $signed({4'b0000, max_len_reg})))
        begin
            lim_next.rp = rp;
        end
        diff = max_len_reg - len_reg[RATE_LAT-1];
        if (lim_next.cls == LIM_REACH)
        begin
            magp = rp[31] ? 32'(~rp + 32'd1) : 32'(rp);
            magm = rm[31] ? 32'(~rm + 32'd1) : 32'(rm);
            den  = inc[31:0];
        end
        else
        begin
            magp = '0;
            magm = '0;
            den  = 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lim_reg[0] <= lim_next;
            magp_reg   <= magp;
            magm_reg   <= magm;
            diff_reg   <= diff;
            den1_reg   <= den;
            nump_reg   <= 63'(magp_reg) * 63'(diff_reg);
            numm_reg   <= 63'(magm_reg) * 63'(diff_reg);
            den2_reg   <= den1_reg;
            for (int i = 1; i <= DIV_BITS + 1; i++)
                lim_reg[i] <= lim_reg[i-1];
        end
    end

    fegr_div u_div_plus
    (
        .clk (clk),
        .en  (en),
        .num (nump_reg),
        .den (den2_reg),
        .quo (qp)
    );

    fegr_div u_div_minus
    (
        .clk (clk),
        .en  (en),
        .num (numm_reg),
        .den (den2_reg),
        .quo (qm)
    );

    always_comb
    begin
        lim_o              = lim_reg[DIV_BITS+1];
        rate_plus_next     = lim_o.rp;
        rate_minus_next    = lim_o.rm;
        applied_plus_next  = '0;
        applied_minus_next = '0;
        remove_next        = 1'b0;
        unique case (lim_o.cls)
            LIM_BELOW:
            begin
                remove_next = !mode_reg[MODE_PERSIST];
            end
            LIM_WITHIN:
            begin
                applied_plus_next  = lim_o.rp;
                applied_minus_next = lim_o.rm;
            end
            LIM_REACH:
            begin
                applied_plus_next  = lim_o.sp ? 32'(~qp + 32'd1) : qp;
                applied_minus_next = lim_o.sm ? 32'(~qm + 32'd1) : qm;
            end
            LIM_ABOVE:
            begin
                rate_plus_next  = '0;
                rate_minus_next = '0;
            end
            default:
            begin
                rate_plus_next  = '0;
                rate_minus_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rate_plus_reg     <= rate_plus_next;
            rate_minus_reg    <= rate_minus_next;
            applied_plus_reg  <= applied_plus_next;
            applied_minus_reg <= applied_minus_next;
            remove_reg        <= remove_next;
        end
    end

    assign growth.valid         = vld_reg[TOP_LAT-1];
    assign growth.rate_plus     = rate_plus_reg;
    assign growth.rate_minus    = rate_minus_reg;
    assign growth.applied_plus  = applied_plus_reg;
    assign growth.applied_minus = applied_minus_reg;
    assign growth.remove_fiber  = remove_reg;

    // a removed fiber never gets growth applied
    assert property (@(posedge clk) disable iff (!rst_n)
        growth.valid && growth.remove_fiber
            |-> growth.applied_plus == 32'sd0 && growth.applied_minus == 32'sd0)
        else $error("removed fiber carries applied growth");

    // persistent fibers are never flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        growth.valid && mode_reg[MODE_PERSIST] |-> !growth.remove_fiber)
        else $error("persistent fiber flagged for removal");

    // during an output stall the output stays valid and the pipeline does not move
    assert property (@(posedge clk) disable iff (!rst_n)
        growth.valid && !growth.ready |=> growth.valid && vld_reg[0] == $past(vld_reg[0]))
        else $error("pipeline moved during a stall");

endmodule
